// ===== hdl/page_frame_bitmap_allocator_assert.svh =====
// Assertion macros for the page frame bitmap allocator.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PFBA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("page frame allocator: forbidden condition");
`define PFBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page frame allocator: implication failed");
`define PFBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page frame allocator: next-cycle check failed");
`else
`define PFBA_ASSERT_NEVER(lbl, expr)
`define PFBA_ASSERT_IMP(lbl, ante, cons)
`define PFBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/pfba_pkg.sv =====
// Package for the page frame bitmap allocator: defaults, codes and state type.
// No dependencies.
`default_nettype none

package pfba_pkg;

	localparam int NUM_FRAMES_DEF = 4096;
	localparam int WORD_BITS_DEF  = 32;

	localparam int FRAME_W = 12;
	localparam int FCOUNT_W = 13;
	localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_NOOP   = 2'd1,
		STAT_NOFREE = 2'd2
	} pfba_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE_WR,
		ST_FIN
	} pfba_state_t;

endpackage

`default_nettype wire

// ===== hdl/page_frame_bitmap_allocator.sv =====
// First-fit page frame allocator over a used-frame bitmap held in one memory.
// Depends on pfba_pkg and page_frame_bitmap_allocator_assert.svh.
//
// Requests enter on the s_ beat channel (tuser = mode: allocate or free),
// results leave on the m_ channel (tuser = status). cfg_wr_en/cfg_wr_data
// set frame_count, the number of frames managed; write it only while idle.
// After reset the bitmap memory is swept to all free, one word per cycle,
// with s_tready low. One request is worked at a time; the bitmap is one
// read port, one write port. Allocation scans one bitmap word per cycle
// starting at word 0, up to the first word with a free bit or the last
// managed word; the next beat is taken once the result has moved to the
// output register. Frees read the word, clear the bit and write it back;
// requests that change nothing (frame already set, free of frame zero) go
// straight to the final step. Each request's word is read one cycle,
// modified and written back the next, and the next request reads only after
// that write, so no forwarding is needed. The result waits in an output
// register; a new request is taken while it waits, and a stalled receiver
// holds the block in its final step only.
`default_nettype none

`include "page_frame_bitmap_allocator_assert.svh"

module page_frame_bitmap_allocator #(
	parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF,  // WORD_BITS .. 4096
	parameter int WORD_BITS  = pfba_pkg::WORD_BITS_DEF    // power of two, 8 .. 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [12:0] cfg_wr_data,    // frame_count
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,        // [11:0] current_frame, [12] user_flag,
	                                         // [13] write_flag, [15:14] zero
	input  wire logic        s_tuser,        // [0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,        // [11:0] frame_out, [12] present_out,
	                                         // [13] user_out, [14] write_out, [15] zero
	output logic [1:0]       m_tuser         // [1:0] status
);

	localparam int NUM_WORDS = NUM_FRAMES / WORD_BITS;
	localparam int SH        = $clog2(WORD_BITS);
	localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int WCNT      = $clog2(NUM_WORDS + 1);
	localparam int CW        = (WCNT > pfba_pkg::FCOUNT_W) ? WCNT : pfba_pkg::FCOUNT_W;
	localparam int FW        = pfba_pkg::FRAME_W;

	// bitmap memory
	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic                 rd_en;
	logic [WIDX-1:0]      rd_addr;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 wr_en;
	logic [WIDX-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	pfba_pkg::pfba_state_t state_q, state_d;

	logic [pfba_pkg::FCOUNT_W-1:0] frame_count_q;
	logic [WIDX-1:0]               clr_idx_q;
	logic [WIDX-1:0]               idx_q;       // word being scanned or freed
	logic [SH-1:0]                 bit_q;
	logic                          user_q;
	logic                          write_q;

	logic                          res_load;
	logic [FW-1:0]                 res_frame_d, res_frame_q;
	logic                          res_present_d, res_present_q;
	logic                          res_user_d, res_user_q;
	logic                          res_write_d, res_write_q;
	pfba_pkg::pfba_status_t        res_status_d, res_status_q;

	logic                          out_load;
	logic                          out_valid_q;
	logic [FW-1:0]                 out_frame_q;
	logic                          out_present_q;
	logic                          out_user_q;
	logic                          out_write_q;
	pfba_pkg::pfba_status_t        out_status_q;

	logic                          accept;
	logic                          in_mode;
	logic [FW-1:0]                 in_frame;
	logic [FW-1:0]                 cur_word;
	logic                          free_in_range;
	logic [CW-1:0]                 fc_words;
	logic [CW-1:0]                 lim_cw;
	logic [WCNT-1:0]               words_lim;
	logic                          scan_last;
	logic                          word_full;
	logic [SH-1:0]                 zero_pos;
	logic [WORD_BITS-1:0]          zero_bit;
	logic [WIDX-1:0]               idx_inc;

	assign accept   = s_tvalid && s_tready;
	assign in_mode  = s_tuser;
	assign in_frame = s_tdata[FW-1:0];
	assign cur_word = in_frame >> SH;
	assign free_in_range = 32'(cur_word) < 32'(NUM_WORDS);

	// only whole words below frame_count are scanned, capped at the memory size
	assign fc_words  = CW'(frame_count_q) >> SH;
	assign lim_cw    = (fc_words > CW'(NUM_WORDS)) ? CW'(NUM_WORDS) : fc_words;
	assign words_lim = WCNT'(lim_cw);
	assign idx_inc   = idx_q + WIDX'(1);
	assign scan_last = (WCNT'(idx_q) + WCNT'(1)) >= words_lim;

	assign word_full = &rd_data_q;

	always_comb begin
		zero_pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!rd_data_q[b]) begin
				zero_pos = SH'(b);
			end
		end
	end

	assign zero_bit = WORD_BITS'(1) << zero_pos;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfba_pkg::ST_CLEAR: begin
				if (clr_idx_q == WIDX'(NUM_WORDS - 1)) state_d = pfba_pkg::ST_IDLE;
			end
			pfba_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_mode == pfba_pkg::MODE_ALLOC) begin
						if (in_frame == '0 && words_lim != '0) state_d = pfba_pkg::ST_SCAN;
						else state_d = pfba_pkg::ST_FIN;
					end else begin
						if (in_frame != '0 && free_in_range) state_d = pfba_pkg::ST_FREE_WR;
						else state_d = pfba_pkg::ST_FIN;
					end
				end
			end
			pfba_pkg::ST_SCAN: begin
				if (!word_full || scan_last) state_d = pfba_pkg::ST_FIN;
			end
			pfba_pkg::ST_FREE_WR: begin
				state_d = pfba_pkg::ST_FIN;
			end
			pfba_pkg::ST_FIN: begin
				if (!out_valid_q || m_tready) state_d = pfba_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfba_pkg::ST_CLEAR;
			end
		endcase
	end

	// outputs of each state
	always_comb begin
		s_tready      = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = '0;
		wr_en         = 1'b0;
		wr_addr       = idx_q;
		wr_data       = '0;
		res_load      = 1'b0;
		res_frame_d   = '0;
		res_present_d = 1'b0;
		res_user_d    = 1'b0;
		res_write_d   = 1'b0;
		res_status_d  = pfba_pkg::STAT_DONE;
		out_load      = 1'b0;
		unique case (state_q)
			pfba_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
			end
			pfba_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (in_mode == pfba_pkg::MODE_ALLOC) begin
						if (in_frame != '0) begin
							res_load     = 1'b1;
							res_frame_d  = in_frame;
							res_status_d = pfba_pkg::STAT_NOOP;
						end else if (words_lim == '0) begin
							res_load     = 1'b1;
							res_status_d = pfba_pkg::STAT_NOFREE;
						end else begin
							rd_en = 1'b1;
						end
					end else begin
						if (in_frame == '0) begin
							res_load     = 1'b1;
							res_status_d = pfba_pkg::STAT_NOOP;
						end else if (free_in_range) begin
							rd_en   = 1'b1;
							rd_addr = WIDX'(cur_word);
						end else begin
							// frame beyond the bitmap: nothing stored to clear
							res_load = 1'b1;
						end
					end
				end
			end
			pfba_pkg::ST_SCAN: begin
				if (!word_full) begin
					wr_en         = 1'b1;
					wr_data       = rd_data_q | zero_bit;
					res_load      = 1'b1;
					res_frame_d   = FW'({idx_q, zero_pos});
					res_present_d = 1'b1;
					res_user_d    = user_q;
					res_write_d   = write_q;
				end else if (scan_last) begin
					res_load     = 1'b1;
					res_status_d = pfba_pkg::STAT_NOFREE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_inc;
				end
			end
			pfba_pkg::ST_FREE_WR: begin
				wr_en    = 1'b1;
				wr_data  = rd_data_q & ~(WORD_BITS'(1) << bit_q);
				res_load = 1'b1;
			end
			pfba_pkg::ST_FIN: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pfba_pkg::ST_CLEAR;
			clr_idx_q     <= '0;
			frame_count_q <= pfba_pkg::FRAME_COUNT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfba_pkg::ST_CLEAR) clr_idx_q <= clr_idx_q + WIDX'(1);
			if (cfg_wr_en) frame_count_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= (in_mode == pfba_pkg::MODE_FREE) ? WIDX'(cur_word) : '0;
			bit_q   <= in_frame[SH-1:0];
			user_q  <= s_tdata[FW];
			write_q <= s_tdata[FW+1];
		end else if (state_q == pfba_pkg::ST_SCAN && rd_en) begin
			idx_q <= idx_inc;
		end
		if (res_load) begin
			res_frame_q   <= res_frame_d;
			res_present_q <= res_present_d;
			res_user_q    <= res_user_d;
			res_write_q   <= res_write_d;
			res_status_q  <= res_status_d;
		end
		if (out_load) begin
			out_frame_q   <= res_frame_q;
			out_present_q <= res_present_q;
			out_user_q    <= res_user_q;
			out_write_q   <= res_write_q;
			out_status_q  <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_write_q, out_user_q, out_present_q, out_frame_q};
	assign m_tuser  = out_status_q;

	`PFBA_ASSERT_IMP(a_scan_in_range, state_q == pfba_pkg::ST_SCAN, WCNT'(idx_q) < words_lim)
	`PFBA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != pfba_pkg::ST_IDLE)
	`PFBA_ASSERT_NEVER(a_no_accept_in_clear, state_q == pfba_pkg::ST_CLEAR && s_tready)
	`PFBA_ASSERT_IMP(a_present_is_done, m_tvalid && out_present_q,
		out_status_q == pfba_pkg::STAT_DONE)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_bitmap_allocator: a directed table, then random
// allocate/free beats under several frame_count settings with random stalls on both sides.
// Depends on pfba_pkg and the allocator RTL; expected entries come from a local bitmap model.
module testbench;

	localparam int MAP_WORDS = pfba_pkg::NUM_FRAMES_DEF / pfba_pkg::WORD_BITS_DEF;
	localparam int WBITS = pfba_pkg::WORD_BITS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 105;
	localparam int SETTLE_CYCLES = 150;

	typedef struct packed {
		logic [pfba_pkg::FRAME_W-1:0] frame;
		logic                         present;
		logic                         usr;
		logic                         wr;
		pfba_pkg::pfba_status_t       status;
	} page_entry_t;

	typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic                          mode;
		logic [pfba_pkg::FRAME_W-1:0]  frame;
		logic                          usr;
		logic                          wr;
		logic [pfba_pkg::FCOUNT_W-1:0] count;
		bit                            typed;
		page_entry_t                   want;
	} stim_row_t;

	localparam page_entry_t NO_ENTRY  = '0;
	localparam page_entry_t FREED     = '{12'd0, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_DONE};
	localparam page_entry_t EXHAUSTED = '{12'd0, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_NOFREE};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [pfba_pkg::FCOUNT_W-1:0] cfg_wr_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]  s_tdata = '0;   // [11:0] current_frame, [12] user_flag, [13] write_flag
	logic         s_tuser = 1'b0; // [0] mode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [15:0]  m_tdata;        // [11:0] frame_out, [12] present, [13] user, [14] write
	logic [1:0]   m_tuser;        // [1:0] status

	// local copy of the allocator state
	logic [WBITS-1:0]              used_map [MAP_WORDS];
	logic [pfba_pkg::FCOUNT_W-1:0] frame_limit;

	page_entry_t                  pending [$];
	logic [pfba_pkg::FRAME_W-1:0] owned [$];
	stim_row_t                    directed [$];

	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int nofree_seen = 0;
	int settings_used = 0;
	int idle_count = 0;
	bit calm = 1'b0;

	page_frame_bitmap_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	// Apply one request to the local bitmap and return the page entry it should yield.
	function automatic page_entry_t next_page_entry(logic mode,
			logic [pfba_pkg::FRAME_W-1:0] frame, logic usr, logic wr);
		page_entry_t r;
		int words;
		bit found;
		r = '0;
		found = 1'b0;
		words = int'(frame_limit) / WBITS;
		if (words > MAP_WORDS)
			words = MAP_WORDS;
		if (mode == pfba_pkg::MODE_FREE) begin
			if (frame == '0)
				r.status = pfba_pkg::STAT_NOOP;
			else
				used_map[frame[11:5]][frame[4:0]] = 1'b0;
		end else if (frame != '0) begin
			r.frame = frame;
			r.status = pfba_pkg::STAT_NOOP;
		end else begin
			for (int w = 0; w < words && !found; w++)
				for (int b = 0; b < WBITS && !found; b++)
					if (!used_map[w][b]) begin
						used_map[w][b] = 1'b1;
						found = 1'b1;
						r.frame = 12'(w * WBITS + b);
						r.present = 1'b1;
						r.usr = usr;
						r.wr = wr;
					end
			if (!found)
				r.status = pfba_pkg::STAT_NOFREE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Offer one beat, hold it until taken, then record what it should produce.
	task automatic send_request(input logic mode, input logic [pfba_pkg::FRAME_W-1:0] frame,
			input logic usr, input logic wr, input bit typed, input page_entry_t want,
			output page_entry_t pred);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, wr, usr, frame};
		s_tuser <= mode;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		pred = next_page_entry(mode, frame, usr, wr);
		pending.push_back(typed ? want : pred);
		requests_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [pfba_pkg::FCOUNT_W-1:0] count);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frame_limit = count;
		settings_used++;
	endtask

	initial begin : stimulus
		page_entry_t pred;
		logic [pfba_pkg::FCOUNT_W-1:0] phase_counts [8];
		logic [pfba_pkg::FRAME_W-1:0] fr;
		logic mode;
		int unsigned roll;
		int pick;

		phase_counts = '{13'd4096, 13'd40, 13'd0, 13'd8191, 13'd64, 13'd4095, 13'd1000,
			13'd4096};
		for (int i = 0; i < MAP_WORDS; i++)
			used_map[i] = '0;
		frame_limit = pfba_pkg::FRAME_COUNT_RESET;

		directed = '{
			// fresh bitmap: lowest frames go out in order, flags copied
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b1, 13'd0, 1'b1,
				'{12'd0, 1'b1, 1'b1, 1'b1, pfba_pkg::STAT_DONE}},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd0, 1'b1,
				'{12'd1, 1'b1, 1'b0, 1'b0, pfba_pkg::STAT_DONE}},
			// entry already holds a frame: left alone; a free of frame zero does nothing
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd4095, 1'b1, 1'b1, 13'd0, 1'b1,
				'{12'd4095, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_NOOP}},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'hAAA, 1'b0, 1'b1, 13'd0, 1'b1,
				'{12'hAAA, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_NOOP}},
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd0, 1'b1, 1'b1, 13'd0, 1'b1,
				'{12'd0, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_NOOP}},
			// free, then free again while already clear
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd1, 1'b0, 1'b0, 13'd0, 1'b1, FREED},
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd1, 1'b0, 1'b0, 13'd0, 1'b1, FREED},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b0, 13'd0, 1'b0, NO_ENTRY},
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd4095, 1'b1, 1'b1, 13'd0, 1'b1, FREED},
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'h555, 1'b1, 1'b1, 13'd0, 1'b1, FREED},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b1, 13'd0, 1'b0, NO_ENTRY},
			// nothing managed: every allocation for an empty entry is out of frames
			'{ROW_CFG, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd0, 1'b0, NO_ENTRY},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b1, 13'd0, 1'b1, EXHAUSTED},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd5, 1'b1, 1'b0, 13'd0, 1'b1,
				'{12'd5, 1'b0, 1'b0, 1'b0, pfba_pkg::STAT_NOOP}},
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd2, 1'b0, 1'b1, 13'd0, 1'b1, FREED},
			// partial word is not scanned
			'{ROW_CFG, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd31, 1'b0, NO_ENTRY},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b1, 13'd0, 1'b1, EXHAUSTED},
			'{ROW_CFG, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd32, 1'b0, NO_ENTRY},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b1, 13'd0, 1'b0, NO_ENTRY},
			// free above the managed count still clears the bit
			'{ROW_REQ, pfba_pkg::MODE_FREE, 12'd100, 1'b0, 1'b0, 13'd0, 1'b1, FREED},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd0, 1'b0, NO_ENTRY},
			// count beyond the bitmap: scan stops at the last word
			'{ROW_CFG, pfba_pkg::MODE_ALLOC, 12'd0, 1'b0, 1'b0, 13'd8191, 1'b0, NO_ENTRY},
			'{ROW_REQ, pfba_pkg::MODE_ALLOC, 12'd0, 1'b1, 1'b1, 13'd0, 1'b0, NO_ENTRY}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[r]) begin
			if (directed[r].kind == ROW_CFG)
				write_frame_count(directed[r].count);
			else
				send_request(directed[r].mode, directed[r].frame, directed[r].usr,
					directed[r].wr, directed[r].typed, directed[r].want, pred);
		end

		foreach (phase_counts[p]) begin
			write_frame_count(phase_counts[p]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 32 == 0)
					calm = ($urandom_range(0, 3) == 0);
				roll = $urandom_range(0, 99);
				fr = 12'($urandom);
				if (roll < 50) begin
					mode = pfba_pkg::MODE_ALLOC;
					fr = '0;
				end else if (roll < 60) begin
					mode = pfba_pkg::MODE_ALLOC;
					if (fr == '0)
						fr = 12'd1;
				end else if (roll < 85 && owned.size() != 0) begin
					mode = pfba_pkg::MODE_FREE;
					pick = $urandom_range(0, owned.size() - 1);
					fr = owned[pick];
					owned.delete(pick);
				end else if (roll < 95) begin
					mode = pfba_pkg::MODE_FREE;
				end else begin
					mode = pfba_pkg::MODE_FREE;
					fr = '0;
				end
				send_request(mode, fr, 1'($urandom), 1'($urandom), 1'b0, NO_ENTRY, pred);
				if (pred.present)
					owned.push_back(pred.frame);
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending.size()));

		$display("summary: %0d requests across %0d frame_count writes, %0d results checked",
			requests_sent, settings_used, results_seen);
		$display("summary: %0d allocations ran out of frames, %0d mismatches",
			nofree_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : result_sink
		int stall;
		page_entry_t got;
		page_entry_t want;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1)
				@(posedge clk);
			got.frame = m_tdata[11:0];
			got.present = m_tdata[12];
			got.usr = m_tdata[13];
			got.wr = m_tdata[14];
			got.status = pfba_pkg::pfba_status_t'(m_tuser);
			results_seen++;
			if (got.status == pfba_pkg::STAT_NOFREE)
				nofree_seen++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending",
					results_seen));
			end else begin
				want = pending.pop_front();
				if (got.frame != want.frame)
					report_mismatch($sformatf("result %0d frame_out %0d, want %0d",
						results_seen, got.frame, want.frame));
				if (got.present != want.present)
					report_mismatch($sformatf("result %0d present_out %b, want %b",
						results_seen, got.present, want.present));
				if (got.usr != want.usr)
					report_mismatch($sformatf("result %0d user_out %b, want %b",
						results_seen, got.usr, want.usr));
				if (got.wr != want.wr)
					report_mismatch($sformatf("result %0d write_out %b, want %b",
						results_seen, got.wr, want.wr));
				if (got.status != want.status)
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						results_seen, got.status, want.status));
			end
		end
	end

	// Drop the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

endmodule
